FILE: design/btxm_pkg.sv
`default_nettype none

package btxm_pkg;

    // Fixed field widths of the request and result channels
    localparam int VAL_W  = 16;
    localparam int MEX_W  = 17;

    // Node pool: one entry per node, index 0 is the root
    localparam int NODE_W = 16;
    localparam int CNT_W  = 17;

    localparam int KEY_BITS_DEF = 16;
    localparam int MAX_KEYS_DEF = 4096;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    typedef struct packed {
        logic [NODE_W-1:0] left;
        logic [NODE_W-1:0] right;
        logic [CNT_W-1:0]  cnt;
    } entry_t;

    // Microprogram step addresses
    localparam int UPC_W = 3;
    localparam logic [UPC_W-1:0] S_IDLE  = 3'd0;
    localparam logic [UPC_W-1:0] S_PROBE = 3'd1;
    localparam logic [UPC_W-1:0] S_ADMIT = 3'd2;
    localparam logic [UPC_W-1:0] S_BUILD = 3'd3;
    localparam logic [UPC_W-1:0] S_LEAF  = 3'd4;
    localparam logic [UPC_W-1:0] S_STEER = 3'd5;
    localparam logic [UPC_W-1:0] S_TEST  = 3'd6;
    localparam logic [UPC_W-1:0] S_EMIT  = 3'd7;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_PROBE,
        OP_ADMIT,
        OP_BUILD,
        OP_LEAF,
        OP_STEER,
        OP_TEST,
        OP_EMIT
    } uop_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_REQ_INS,
        C_REQ_QRY,
        C_NOCHILD,
        C_LAST,
        C_DROP,
        C_FULLSET,
        C_DEAD,
        C_OUTFREE
    } cond_t;

    typedef struct packed {
        uop_t             op;
        cond_t            ca;
        logic [UPC_W-1:0] ta;
        cond_t            cb;
        logic [UPC_W-1:0] tb;
        logic [UPC_W-1:0] tc;
    } ctl_t;

    typedef struct packed {
        logic req_ins;
        logic req_qry;
        logic nochild;
        logic last;
        logic drop;
        logic fullset;
        logic dead;
        logic out_free;
    } flags_t;

    // Control store: first condition wins, else second, else fall to tc
    function automatic ctl_t ucode(input logic [UPC_W-1:0] a);
        ctl_t w;
        case (a)
            S_IDLE:  w = '{op: OP_LOAD,  ca: C_REQ_INS, ta: S_PROBE,
                           cb: C_REQ_QRY, tb: S_STEER, tc: S_IDLE};
            S_PROBE: w = '{op: OP_PROBE, ca: C_NOCHILD, ta: S_ADMIT,
                           cb: C_LAST,    tb: S_IDLE,  tc: S_PROBE};
            S_ADMIT: w = '{op: OP_ADMIT, ca: C_DROP,    ta: S_IDLE,
                           cb: C_NEVER,   tb: S_IDLE,  tc: S_BUILD};
            S_BUILD: w = '{op: OP_BUILD, ca: C_LAST,    ta: S_LEAF,
                           cb: C_NEVER,   tb: S_IDLE,  tc: S_BUILD};
            S_LEAF:  w = '{op: OP_LEAF,  ca: C_NEVER,   ta: S_IDLE,
                           cb: C_NEVER,   tb: S_IDLE,  tc: S_IDLE};
            S_STEER: w = '{op: OP_STEER, ca: C_FULLSET, ta: S_EMIT,
                           cb: C_NOCHILD, tb: S_EMIT,  tc: S_TEST};
            S_TEST:  w = '{op: OP_TEST,  ca: C_LAST,    ta: S_EMIT,
                           cb: C_DEAD,    tb: S_EMIT,  tc: S_STEER};
            S_EMIT:  w = '{op: OP_EMIT,  ca: C_OUTFREE, ta: S_IDLE,
                           cb: C_NEVER,   tb: S_IDLE,  tc: S_EMIT};
            default: w = '{op: OP_NOP,   ca: C_NEVER,   ta: S_IDLE,
                           cb: C_NEVER,   tb: S_IDLE,  tc: S_IDLE};
        endcase
        return w;
    endfunction

    function automatic logic cond_hit(input cond_t c, input flags_t f);
        logic h;
        case (c)
            C_NEVER:   h = 1'b0;
            C_REQ_INS: h = f.req_ins;
            C_REQ_QRY: h = f.req_qry;
            C_NOCHILD: h = f.nochild;
            C_LAST:    h = f.last;
            C_DROP:    h = f.drop;
            C_FULLSET: h = f.fullset;
            C_DEAD:    h = f.dead;
            C_OUTFREE: h = f.out_free;
            default:   h = 1'b0;
        endcase
        return h;
    endfunction

endpackage

`default_nettype wire

FILE: design/btxm_req_if.sv
`default_nettype none

interface btxm_req_if;
    logic                      valid;
    logic                      ready;
    logic                      cmd;
    logic [btxm_pkg::VAL_W-1:0] value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

`default_nettype wire

FILE: design/btxm_rsp_if.sv
`default_nettype none

interface btxm_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [btxm_pkg::MEX_W-1:0] mex_value;

    modport source (output valid, output mex_value, input ready);
    modport sink   (input valid, input mex_value, output ready);
endinterface

`default_nettype wire

FILE: design/binary_trie_xor_mex.sv
`default_nettype none

// channel  dir  payload                    request moves
// -------  ---  -------------------------  -----------------------------------
// req      in   cmd[0], value[15:0]        insert key, or fold mask and query
// rsp      out  mex_value[16:0]            one per query, none per insert
//
// Insert steps: accept, probe walk, admit check, build walk, leaf write; a
// duplicate ends after the probe walk, a dropped key after the admit check.
// Query steps: accept, then per trie level a step that reads the child and a
// step that tests it, then the result step. The single node memory has a
// registered read. Reset takes effect at once: nodes are claimed in order and
// read only after they were written, and a flop marks the root. A result waits
// in the output register; the next request is taken meanwhile, and a later
// query holds at its result step until that register is free.
module binary_trie_xor_mex #(
    parameter int KEY_BITS = btxm_pkg::KEY_BITS_DEF,
    parameter int MAX_KEYS = btxm_pkg::MAX_KEYS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    btxm_req_if.sink      req,
    btxm_rsp_if.source    rsp
);

    localparam int LW    = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
    localparam int MIS_W = $clog2(KEY_BITS + 1);
    localparam int POOL  = 2 ** btxm_pkg::NODE_W;
    localparam logic [LW-1:0] TOP = LW'(KEY_BITS - 1);
    localparam logic [31:0] FULL_SET = 32'd1 << KEY_BITS;

    logic [btxm_pkg::UPC_W-1:0] upc_reg, upc_next;
    btxm_pkg::ctl_t   ctl;
    btxm_pkg::flags_t flg;

    logic                          cmd_reg, cmd_next;
    logic [KEY_BITS-1:0]           key_reg, key_next;
    logic [KEY_BITS-1:0]           mask_reg, mask_next;
    logic [KEY_BITS-1:0]           res_reg, res_next;
    logic [LW-1:0]                 lvl_reg, lvl_next;
    logic [MIS_W-1:0]              miss_reg, miss_next;
    logic [btxm_pkg::NODE_W-1:0]   cur_reg, cur_next;
    logic [btxm_pkg::NODE_W-1:0]   alt_reg, alt_next;
    logic [btxm_pkg::NODE_W-1:0]   nodes_reg, nodes_next;
    logic [btxm_pkg::CNT_W-1:0]    total_reg, total_next;
    logic                          fresh_reg, fresh_next;
    logic                          root_valid_reg, root_valid_next;
    logic                          out_valid_reg, out_valid_next;
    logic [btxm_pkg::MEX_W-1:0]    out_data_reg, out_data_next;

    btxm_pkg::entry_t              node_mem [POOL];
    btxm_pkg::entry_t              rd_data_reg;
    logic                          rd_zero_reg;

    logic                          rd_en;
    logic [btxm_pkg::NODE_W-1:0]   rd_addr;
    logic                          wr_en;
    logic [btxm_pkg::NODE_W-1:0]   wr_addr;
    btxm_pkg::entry_t              wr_data;

    btxm_pkg::entry_t              ent;
    btxm_pkg::entry_t              e_eff;
    logic                          accept;
    logic                          sbit;
    logic                          sat;
    logic                          new_node;
    logic [btxm_pkg::NODE_W-1:0]   child;
    logic [btxm_pkg::NODE_W-1:0]   alt;
    logic [btxm_pkg::NODE_W-1:0]   nxt;
    logic [btxm_pkg::NODE_W:0]     need_nodes;
    logic [btxm_pkg::MEX_W-1:0]    mex;

    assign ctl       = btxm_pkg::ucode(upc_reg);
    assign req.ready = (ctl.op == btxm_pkg::OP_LOAD);
    assign accept    = req.valid && req.ready;

    assign rsp.valid     = out_valid_reg;
    assign rsp.mex_value = out_data_reg;

    // Root entry reads as empty until the first insert writes it
    assign ent   = (rd_zero_reg && !root_valid_reg) ? '0 : rd_data_reg;
    assign e_eff = fresh_reg ? '0 : ent;

    assign sbit  = (cmd_reg == btxm_pkg::CMD_QUERY) ? mask_reg[lvl_reg] : key_reg[lvl_reg];
    assign child = sbit ? e_eff.right : e_eff.left;
    assign alt   = sbit ? e_eff.left : e_eff.right;
    assign sat   = (32'(ent.cnt) == (32'd1 << lvl_reg));
    assign new_node = (child == '0);
    assign nxt   = new_node ? nodes_reg + btxm_pkg::NODE_W'(1) : child;
    assign need_nodes = {1'b0, nodes_reg} + (btxm_pkg::NODE_W + 1)'(miss_reg);
    assign mex   = flg.fullset ? FULL_SET[btxm_pkg::MEX_W-1:0]
                               : btxm_pkg::MEX_W'(res_reg);

    always_comb
    begin
        flg.req_ins  = req.valid && (req.cmd == btxm_pkg::CMD_INSERT);
        flg.req_qry  = req.valid && (req.cmd == btxm_pkg::CMD_QUERY);
        flg.nochild  = (child == '0);
        flg.last     = (lvl_reg == '0);
        flg.drop     = (total_reg >= btxm_pkg::CNT_W'(MAX_KEYS))
                    || (need_nodes > {1'b0, {btxm_pkg::NODE_W{1'b1}}});
        flg.fullset  = (32'(total_reg) >= FULL_SET);
        flg.dead     = sat && (alt_reg == '0);
        flg.out_free = !out_valid_reg || rsp.ready;
    end

    always_comb
    begin
        if (btxm_pkg::cond_hit(ctl.ca, flg))
        begin
            upc_next = ctl.ta;
        end
        else if (btxm_pkg::cond_hit(ctl.cb, flg))
        begin
            upc_next = ctl.tb;
        end
        else
        begin
            upc_next = ctl.tc;
        end
    end

    always_comb
    begin
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        mask_next       = mask_reg;
        res_next        = res_reg;
        lvl_next        = lvl_reg;
        miss_next       = miss_reg;
        cur_next        = cur_reg;
        alt_next        = alt_reg;
        nodes_next      = nodes_reg;
        total_next      = total_reg;
        fresh_next      = fresh_reg;
        root_valid_next = root_valid_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_data_next   = out_data_reg;
        rd_en           = 1'b0;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = cur_reg;
        wr_data         = '0;

        case (ctl.op)
            btxm_pkg::OP_LOAD:
            begin
                if (accept)
                begin
                    cmd_next = req.cmd;
                    key_next = KEY_BITS'(req.value);
                    if (req.cmd == btxm_pkg::CMD_QUERY)
                    begin
                        mask_next = mask_reg ^ KEY_BITS'(req.value);
                    end
                    res_next   = '0;
                    lvl_next   = TOP;
                    cur_next   = '0;
                    fresh_next = 1'b0;
                    rd_en      = 1'b1;
                end
            end
            btxm_pkg::OP_PROBE:
            begin
                if (child == '0)
                begin
                    miss_next = MIS_W'(lvl_reg) + MIS_W'(1);
                end
                else if (!flg.last)
                begin
                    lvl_next = lvl_reg - LW'(1);
                    rd_en    = 1'b1;
                    rd_addr  = child;
                end
            end
            btxm_pkg::OP_ADMIT:
            begin
                if (!flg.drop)
                begin
                    total_next = total_reg + btxm_pkg::CNT_W'(1);
                    lvl_next   = TOP;
                    cur_next   = '0;
                    fresh_next = 1'b0;
                    rd_en      = 1'b1;
                end
            end
            btxm_pkg::OP_BUILD:
            begin
                // Link the child, bump the count, claim a node where none exists
                wr_en         = 1'b1;
                wr_data.left  = sbit ? e_eff.left : nxt;
                wr_data.right = sbit ? nxt : e_eff.right;
                wr_data.cnt   = e_eff.cnt + btxm_pkg::CNT_W'(1);
                if (cur_reg == '0)
                begin
                    root_valid_next = 1'b1;
                end
                if (new_node)
                begin
                    nodes_next = nxt;
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = nxt;
                end
                fresh_next = new_node;
                cur_next   = nxt;
                if (!flg.last)
                begin
                    lvl_next = lvl_reg - LW'(1);
                end
            end
            btxm_pkg::OP_LEAF:
            begin
                wr_en         = 1'b1;
                wr_data.left  = e_eff.left;
                wr_data.right = e_eff.right;
                wr_data.cnt   = e_eff.cnt + btxm_pkg::CNT_W'(1);
            end
            btxm_pkg::OP_STEER:
            begin
                if (!flg.fullset && (child != '0))
                begin
                    alt_next = alt;
                    rd_en    = 1'b1;
                    rd_addr  = child;
                end
            end
            btxm_pkg::OP_TEST:
            begin
                // Full subtree on the masked side: turn to the sibling
                if (sat)
                begin
                    res_next = res_reg | (KEY_BITS'(1) << lvl_reg);
                end
                if (!flg.last)
                begin
                    lvl_next = lvl_reg - LW'(1);
                    if (sat && (alt_reg != '0))
                    begin
                        rd_en   = 1'b1;
                        rd_addr = alt_reg;
                    end
                end
            end
            btxm_pkg::OP_EMIT:
            begin
                if (flg.out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = mex;
                end
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg        <= btxm_pkg::S_IDLE;
            mask_reg       <= '0;
            nodes_reg      <= '0;
            total_reg      <= '0;
            fresh_reg      <= 1'b0;
            root_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            rd_zero_reg    <= 1'b1;
        end
        else
        begin
            upc_reg        <= upc_next;
            mask_reg       <= mask_next;
            nodes_reg      <= nodes_next;
            total_reg      <= total_next;
            fresh_reg      <= fresh_next;
            root_valid_reg <= root_valid_next;
            out_valid_reg  <= out_valid_next;
            if (rd_en)
            begin
                rd_zero_reg <= (rd_addr == '0);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        key_reg      <= key_next;
        res_reg      <= res_next;
        lvl_reg      <= lvl_next;
        miss_reg     <= miss_next;
        cur_reg      <= cur_next;
        alt_reg      <= alt_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            node_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= node_mem[rd_addr];
        end
    end

    a_write_on_insert: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (cmd_reg == btxm_pkg::CMD_INSERT))
        else $error("node write during a query");

    a_no_port_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_en && wr_en) |-> (rd_addr != wr_addr))
        else $error("node read and write hit the same entry");

    a_root_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        root_valid_reg |=> root_valid_reg)
        else $error("root valid flag fell");

    a_key_limit: assert property (@(posedge clk) disable iff (!rst_n)
        32'(total_reg) <= 32'(MAX_KEYS))
        else $error("stored key count above limit");

endmodule

`default_nettype wire
